// File: sv/mmspc_pkg.sv
// ----------------------------------------------------------------------------
// mmspc_pkg
// Types, codes and helpers shared by the min/max segment prune check.
// ----------------------------------------------------------------------------
`default_nettype none
package mmspc_pkg;

  localparam int QueueDepth = 4;
  localparam int NumOpnd = 3;  // 0 predicate constant, 1 minimum, 2 maximum

  localparam logic [3:0] TY_U8  = 4'd0;
  localparam logic [3:0] TY_U16 = 4'd1;
  localparam logic [3:0] TY_U32 = 4'd2;
  localparam logic [3:0] TY_U64 = 4'd3;
  localparam logic [3:0] TY_I8  = 4'd4;
  localparam logic [3:0] TY_I16 = 4'd5;
  localparam logic [3:0] TY_I32 = 4'd6;
  localparam logic [3:0] TY_I64 = 4'd7;
  localparam logic [3:0] TY_F32 = 4'd8;
  localparam logic [3:0] TY_F64 = 4'd9;
  localparam logic [3:0] TY_TS  = 4'd10;

  localparam logic [2:0] OP_LT = 3'd0;
  localparam logic [2:0] OP_LE = 3'd1;
  localparam logic [2:0] OP_GT = 3'd2;
  localparam logic [2:0] OP_GE = 3'd3;
  localparam logic [2:0] OP_EQ = 3'd4;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

  typedef struct packed {
    logic [2:0] eff_op;
    logic       may_prune;
    logic       last;
    logic       use_int_min;
    logic       use_int_max;
    cmp_t       int_min;
    cmp_t       int_max;
  } ctrl_t;

  typedef struct packed {
    logic [63:0] pred_value;
    logic [3:0]  pred_type;
    logic [63:0] min_stat;
    logic [3:0]  min_type;
    logic [63:0] max_stat;
    logic [3:0]  max_type;
    ctrl_t       ctrl;
  } item_t;

  // operand on its way to double: either passed through or a magnitude to normalize
  typedef struct packed {
    logic        pass;
    logic [63:0] pass_bits;
    logic        sign;
    logic [63:0] mag;
    logic [11:0] offset;
  } conv_t;

  function automatic logic is_bad(input logic [3:0] ty);
    is_bad = (ty > TY_TS);
  endfunction

  function automatic logic is_int(input logic [3:0] ty);
    is_int = (ty <= TY_I64) || (ty == TY_TS);
  endfunction

  function automatic logic is_signed_int(input logic [3:0] ty);
    is_signed_int = ((ty >= TY_I8) && (ty <= TY_I64)) || (ty == TY_TS);
  endfunction

  function automatic logic [63:0] int_ext(input logic [63:0] raw, input logic [3:0] ty);
    logic [63:0] v;
    v = raw;
    unique case (ty)
      TY_U8:   v = {56'd0, raw[7:0]};
      TY_U16:  v = {48'd0, raw[15:0]};
      TY_U32:  v = {32'd0, raw[31:0]};
      TY_I8:   v = {{56{raw[7]}}, raw[7:0]};
      TY_I16:  v = {{48{raw[15]}}, raw[15:0]};
      TY_I32:  v = {{32{raw[31]}}, raw[31:0]};
      default: v = raw;
    endcase
    return v;
  endfunction

  function automatic cmp_t int_cmp(input logic [63:0] a, input logic [63:0] b,
                                   input logic sgn);
    cmp_t r;
    logic [63:0] ka;
    logic [63:0] kb;
    ka = {a[63] ^ sgn, a[62:0]};
    kb = {b[63] ^ sgn, b[62:0]};
    r.lt = ka < kb;
    r.gt = ka > kb;
    return r;
  endfunction

  function automatic conv_t conv_decode(input logic [63:0] raw, input logic [3:0] ty);
    conv_t c;
    logic [63:0] v;
    c = '0;
    if (ty == TY_F64) begin
      c.pass = 1'b1;
      c.pass_bits = raw;
    end else if (ty == TY_F32) begin
      c.sign = raw[31];
      if (raw[30:23] == 8'hFF) begin
        c.pass = 1'b1;
        c.pass_bits = {raw[31], 11'h7FF, raw[22:0], 29'd0};
      end else if (raw[30:23] == 8'd0) begin
        // subnormal: mantissa times 2^-149
        c.mag = {41'd0, raw[22:0]};
        c.offset = -12'sd149;
      end else begin
        c.mag = {40'd0, 1'b1, raw[22:0]};
        c.offset = {4'd0, raw[30:23]} - 12'd150;
      end
    end else begin
      v = int_ext(raw, ty);
      c.sign = is_signed_int(ty) & v[63];
      c.mag = c.sign ? (~v + 64'd1) : v;
    end
    return c;
  endfunction

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  function automatic cmp_t dbl_cmp(input logic [63:0] a, input logic [63:0] b);
    cmp_t r;
    logic nan_a;
    logic nan_b;
    logic [63:0] ka;
    logic [63:0] kb;
    nan_a = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    nan_b = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    r = '0;
    // nan and signed zeros compare equal
    if (!nan_a && !nan_b && !((a[62:0] == '0) && (b[62:0] == '0))) begin
      r.lt = ka < kb;
      r.gt = ka > kb;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/min_max_segment_prune_check.sv
// ----------------------------------------------------------------------------
// min_max_segment_prune_check
// Zone-map min/max check of one predicate per beat, with a running segment OR.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | predicate, min and max stats, operator, flags
//   out     | out_valid / out_ready| prune_by_this, prune_segment, list_done
//
// one beat per cycle sustained while out_ready stays high; each beat passes the queue,
// the double conversion pipe (decode, zero count, shift, round) and the output register
// rst clears the queue, pipe valids, output valid and the running or
// a stalled output freezes the back pipe; the queue keeps taking beats until full
`default_nettype none
module min_max_segment_prune_check #(
  parameter int QUEUE_DEPTH = mmspc_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] pred_value,
  input  wire logic [3:0]  pred_type,
  input  wire logic [63:0] min_stat,
  input  wire logic [3:0]  min_type,
  input  wire logic [63:0] max_stat,
  input  wire logic [3:0]  max_type,
  input  wire logic [2:0]  op_code,
  input  wire logic        col_on_left,
  input  wire logic        stats_present,
  input  wire logic        last_predicate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             prune_by_this,
  output logic             prune_segment,
  output logic             list_done
);
  import mmspc_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_data;

  mmspc_front u_front (
    .in_valid, .in_ready, .pred_value, .pred_type, .min_stat, .min_type,
    .max_stat, .max_type, .op_code, .col_on_left, .stats_present,
    .last_predicate, .push_valid, .push_ready, .push_data
  );

  mmspc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data
  );

  mmspc_back u_back (
    .clk, .rst, .pop_valid, .pop_ready, .pop_data,
    .out_valid, .out_ready, .prune_by_this, .prune_segment, .list_done
  );

endmodule
`default_nettype wire

// File: sv/mmspc_front.sv
// ----------------------------------------------------------------------------
// mmspc_front
// Accepts predicate beats, resolves operator side and native integer compares.
// ----------------------------------------------------------------------------
`default_nettype none
module mmspc_front (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [63:0]          pred_value,
  input  wire logic [3:0]           pred_type,
  input  wire logic [63:0]          min_stat,
  input  wire logic [3:0]           min_type,
  input  wire logic [63:0]          max_stat,
  input  wire logic [3:0]           max_type,
  input  wire logic [2:0]           op_code,
  input  wire logic                 col_on_left,
  input  wire logic                 stats_present,
  input  wire logic                 last_predicate,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output mmspc_pkg::item_t          push_data
);
  import mmspc_pkg::*;

  logic [2:0]  eff_op;
  logic [63:0] pv;
  logic [63:0] mnv;
  logic [63:0] mxv;
  logic        sgn;

  always_comb begin
    eff_op = op_code;
    if (!col_on_left) begin
      unique case (op_code)
        OP_LT:   eff_op = OP_GT;
        OP_LE:   eff_op = OP_GE;
        OP_GT:   eff_op = OP_LT;
        OP_GE:   eff_op = OP_LE;
        default: eff_op = op_code;
      endcase
    end
  end

  assign pv  = int_ext(pred_value, pred_type);
  assign mnv = int_ext(min_stat, min_type);
  assign mxv = int_ext(max_stat, max_type);
  assign sgn = is_signed_int(pred_type);

  always_comb begin
    push_data.pred_value = pred_value;
    push_data.pred_type  = pred_type;
    push_data.min_stat   = min_stat;
    push_data.min_type   = min_type;
    push_data.max_stat   = max_stat;
    push_data.max_type   = max_type;
    push_data.ctrl.eff_op    = eff_op;
    push_data.ctrl.may_prune = stats_present && !is_bad(pred_type) && !is_bad(min_type)
                               && !is_bad(max_type) && (op_code <= OP_EQ);
    push_data.ctrl.last        = last_predicate;
    push_data.ctrl.use_int_min = is_int(pred_type) && (pred_type == min_type);
    push_data.ctrl.use_int_max = is_int(pred_type) && (pred_type == max_type);
    push_data.ctrl.int_min     = int_cmp(pv, mnv, sgn);
    push_data.ctrl.int_max     = int_cmp(pv, mxv, sgn);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule
`default_nettype wire

// File: sv/mmspc_queue.sv
// ----------------------------------------------------------------------------
// mmspc_queue
// Small queue between the classify front and the compare back.
// ----------------------------------------------------------------------------
`default_nettype none
module mmspc_queue #(
  parameter int DEPTH = mmspc_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire mmspc_pkg::item_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output mmspc_pkg::item_t      pop_data
);
  import mmspc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/mmspc_back.sv
// ----------------------------------------------------------------------------
// mmspc_back
// Converts operands to double, compares, decides and keeps the running OR.
// ----------------------------------------------------------------------------
`default_nettype none
module mmspc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire mmspc_pkg::item_t pop_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  prune_by_this,
  output logic                  prune_segment,
  output logic                  list_done
);
  import mmspc_pkg::*;

  logic        adv;
  logic        v1, v2, v3, v4;
  ctrl_t       c1, c2, c3, c4;
  conv_t       s1 [NumOpnd];
  conv_t       s2 [NumOpnd];
  logic [6:0]  s2_lzc [NumOpnd];
  logic        s3_pass [NumOpnd];
  logic [63:0] s3_pass_bits [NumOpnd];
  logic        s3_sign [NumOpnd];
  logic        s3_zero [NumOpnd];
  logic [63:0] s3_norm [NumOpnd];
  logic [11:0] s3_exp [NumOpnd];
  logic [63:0] s4 [NumOpnd];
  logic        acc;
  cmp_t        cmp_min;
  cmp_t        cmp_max;
  logic        this_one;

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1[0] <= conv_decode(pop_data.pred_value, pop_data.pred_type);
      s1[1] <= conv_decode(pop_data.min_stat, pop_data.min_type);
      s1[2] <= conv_decode(pop_data.max_stat, pop_data.max_type);
      c1 <= pop_data.ctrl;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      for (int i = 0; i < NumOpnd; i++) begin
        s2[i]     <= s1[i];
        s2_lzc[i] <= lzc64(s1[i].mag);
        s3_pass[i]      <= s2[i].pass;
        s3_pass_bits[i] <= s2[i].pass_bits;
        s3_sign[i]      <= s2[i].sign;
        s3_zero[i]      <= (s2_lzc[i] == 7'd64);
        s3_norm[i]      <= s2[i].mag << s2_lzc[i][5:0];
        s3_exp[i]       <= 12'd1086 - {5'd0, s2_lzc[i]} + s2[i].offset;
        if (s3_pass[i]) begin
          s4[i] <= s3_pass_bits[i];
        end else if (s3_zero[i]) begin
          s4[i] <= {s3_sign[i], 63'd0};
        end else begin
          // round to nearest even, carry runs into the exponent
          s4[i] <= {s3_sign[i], {s3_exp[i][10:0], s3_norm[i][62:11]}
                    + 63'(s3_norm[i][10] & ((|s3_norm[i][9:0]) | s3_norm[i][11]))};
        end
      end
    end
  end

  always_comb begin
    cmp_min = c4.use_int_min ? c4.int_min : dbl_cmp(s4[0], s4[1]);
    cmp_max = c4.use_int_max ? c4.int_max : dbl_cmp(s4[0], s4[2]);
    this_one = 1'b0;
    if (c4.may_prune) begin
      unique case (c4.eff_op)
        OP_LT:   this_one = !cmp_min.gt;
        OP_LE:   this_one = cmp_min.lt;
        OP_GT:   this_one = !cmp_max.lt;
        OP_GE:   this_one = cmp_max.gt;
        default: this_one = cmp_min.lt || cmp_max.gt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v4) begin
      prune_by_this <= this_one;
      prune_segment <= acc | this_one;
      list_done     <= c4.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
      acc <= 1'b0;
    end else if (adv) begin
      v1 <= pop_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
      if (v4) begin
        acc <= c4.last ? 1'b0 : (acc | this_one);
      end
    end
  end

  a_seg_covers_this: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prune_segment || !prune_by_this))
    else $error("segment flag below predicate flag");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && v4 && c4.last |=> !acc)
    else $error("running or not cleared after last beat");

  a_no_prune: assert property (@(posedge clk) disable iff (rst)
    adv && v4 && !c4.may_prune |=> !prune_by_this)
    else $error("pruned without stats or with bad type");

endmodule
`default_nettype wire

// File: test/prune_check_monitor.sv
// ----------------------------------------------------------------------------
// prune_check_monitor
// Watches both channels of the min/max segment prune check. It predicts each
// beat's prune decision, running segment flag and list end, then compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module prune_check_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] pred_value,
  input  logic [3:0]  pred_type,
  input  logic [63:0] min_stat,
  input  logic [3:0]  min_type,
  input  logic [63:0] max_stat,
  input  logic [3:0]  max_type,
  input  logic [2:0]  op_code,
  input  logic        col_on_left,
  input  logic        stats_present,
  input  logic        last_predicate,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        prune_by_this,
  input  logic        prune_segment,
  input  logic        list_done,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          pruned_count
);
  import mmspc_pkg::*;

  typedef struct packed {
    logic this_prune;
    logic seg_prune;
    logic done;
  } verdict_t;

  verdict_t verdicts[$];
  logic     seg_or;

  function automatic logic [63:0] widen_int(input logic [63:0] raw, input logic [3:0] ty);
    case (ty)
      TY_U8:   return {56'd0, raw[7:0]};
      TY_U16:  return {48'd0, raw[15:0]};
      TY_U32:  return {32'd0, raw[31:0]};
      TY_I8:   return {{56{raw[7]}}, raw[7:0]};
      TY_I16:  return {{48{raw[15]}}, raw[15:0]};
      TY_I32:  return {{32{raw[31]}}, raw[31:0]};
      default: return raw;
    endcase
  endfunction

  function automatic logic signed_kind(input logic [3:0] ty);
    return (ty >= TY_I8 && ty <= TY_I64) || ty == TY_TS;
  endfunction

  // integer magnitude to double, round half to even
  function automatic logic [63:0] int_to_double(input logic sgn, input logic [63:0] mag);
    int          msb;
    int          sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    logic [10:0] expo;
    msb = -1;
    for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
    if (msb < 0) return 64'd0;
    expo = 11'(1023 + msb);
    if (msb <= 52) begin
      keep = mag << (52 - msb);
    end else begin
      sh = msb - 52;
      keep = mag >> sh;
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      if (keep[53]) begin
        keep = keep >> 1;
        expo = expo + 11'd1;
      end
    end
    return {sgn, expo, keep[51:0]};
  endfunction

  function automatic logic [63:0] single_to_double(input logic [31:0] f);
    int          msb;
    logic [63:0] frac;
    if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
    if (f[30:23] != 8'd0)
      return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
    if (f[22:0] == '0) return {f[31], 63'd0};
    msb = 0;
    for (int i = 0; i < 23; i++) if (f[i]) msb = i;
    frac = {41'd0, f[22:0]} << (52 - msb);
    return {f[31], 11'(1023 + msb - 149), frac[51:0]};
  endfunction

  function automatic logic [63:0] as_double(input logic [63:0] raw, input logic [3:0] ty);
    logic [63:0] v;
    logic        neg;
    if (ty == TY_F64) return raw;
    if (ty == TY_F32) return single_to_double(raw[31:0]);
    v = widen_int(raw, ty);
    neg = signed_kind(ty) && v[63];
    return int_to_double(neg, neg ? -v : v);
  endfunction

  // -1, 0 or 1; nan and zeros of either sign come out equal
  function automatic int order_double(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ka;
    logic [63:0] kb;
    if ((a[62:52] == 11'h7FF && a[51:0] != '0) || (b[62:52] == 11'h7FF && b[51:0] != '0))
      return 0;
    if (a[62:0] == '0 && b[62:0] == '0) return 0;
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    return (ka < kb) ? -1 : (ka > kb) ? 1 : 0;
  endfunction

  function automatic int order_values(input logic [63:0] av, input logic [3:0] at,
                                      input logic [63:0] bv, input logic [3:0] bt);
    logic [63:0] a;
    logic [63:0] b;
    if (at == bt && at != TY_F32 && at != TY_F64) begin
      a = widen_int(av, at);
      b = widen_int(bv, bt);
      if (signed_kind(at)) begin
        a[63] = ~a[63];
        b[63] = ~b[63];
      end
      return (a < b) ? -1 : (a > b) ? 1 : 0;
    end
    return order_double(as_double(av, at), as_double(bv, bt));
  endfunction

  function automatic logic rules_out_zone(
      input logic [63:0] pv, input logic [3:0] pt, input logic [63:0] lov,
      input logic [3:0] lot, input logic [63:0] hiv, input logic [3:0] hit,
      input logic [2:0] op, input logic col_left, input logic have_stats);
    int         vs_min;
    int         vs_max;
    logic [2:0] eff;
    if (!have_stats || pt > TY_TS || lot > TY_TS || hit > TY_TS || op > OP_EQ) return 1'b0;
    vs_min = order_values(pv, pt, lov, lot);
    vs_max = order_values(pv, pt, hiv, hit);
    eff = op;
    if (!col_left) begin
      case (op)
        OP_LT: eff = OP_GT;
        OP_LE: eff = OP_GE;
        OP_GT: eff = OP_LT;
        OP_GE: eff = OP_LE;
        default: eff = op;
      endcase
    end
    case (eff)
      OP_LT:   return vs_min <= 0;
      OP_LE:   return vs_min < 0;
      OP_GT:   return vs_max >= 0;
      OP_GE:   return vs_max > 0;
      default: return vs_min < 0 || vs_max > 0;
    endcase
  endfunction

  assign pending = verdicts.size();

  always @(posedge clk) begin
    verdict_t v;
    verdict_t got;
    if (rst) begin
      seg_or <= 1'b0;
      verdicts.delete();
      fail_count <= 0;
      checked_count <= 0;
      pruned_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        v.this_prune = rules_out_zone(pred_value, pred_type, min_stat, min_type,
                                      max_stat, max_type, op_code, col_on_left,
                                      stats_present);
        v.seg_prune = seg_or | v.this_prune;
        v.done = last_predicate;
        seg_or <= last_predicate ? 1'b0 : v.seg_prune;
        verdicts.insert(verdicts.size(), v);
      end
      if (out_valid && out_ready) begin
        checked_count <= checked_count + 1;
        if (verdicts.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          v = verdicts.pop_front();
          got = '{prune_by_this, prune_segment, list_done};
          if (v.this_prune) pruned_count <= pruned_count + 1;
          if (got != v) begin
            if (got.this_prune != v.this_prune)
              $error("prune_by_this: expected %0b, got %0b", v.this_prune, got.this_prune);
            if (got.seg_prune != v.seg_prune)
              $error("prune_segment: expected %0b, got %0b", v.seg_prune, got.seg_prune);
            if (got.done != v.done)
              $error("list_done: expected %0b, got %0b", v.done, got.done);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives predicate beats with random gaps and output stalls into the prune
// check; a monitor beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module testbench;
  import mmspc_pkg::*;

  localparam logic [3:0] TY_BAD   = 4'd11;
  localparam logic [2:0] OP_OTHER = 3'd5;
  localparam int RandomBeats = 1850;
  localparam int CycleLimit  = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] pred_value = '0;
  logic [3:0]  pred_type = '0;
  logic [63:0] min_stat = '0;
  logic [3:0]  min_type = '0;
  logic [63:0] max_stat = '0;
  logic [3:0]  max_type = '0;
  logic [2:0]  op_code = '0;
  logic        col_on_left = 1'b0;
  logic        stats_present = 1'b0;
  logic        last_predicate = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        prune_by_this;
  logic        prune_segment;
  logic        list_done;
  int          fail_count;
  int          pending;
  int          checked_count;
  int          pruned_count;
  int          cycle_count = 0;
  logic        stall_enable = 1'b1;
  int          stall_left = 0;

  always #5 clk = ~clk;

  min_max_segment_prune_check DUT (.*);

  prune_check_monitor monitor (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall before each result beat
  always @(posedge clk) begin
    int wait_draw;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_ready && out_valid) begin
      wait_draw = stall_enable ? $urandom_range(0, 6) : 0;
      stall_left <= wait_draw;
      out_ready <= (wait_draw == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end
  end

  function automatic logic [63:0] pick_raw(input logic [3:0] ty);
    case ($urandom_range(0, 9))
      0, 1, 2: return {$urandom, $urandom};
      3: return 64'($urandom_range(0, 4));
      4: return -64'($urandom_range(1, 3));
      5: return ty == TY_F32 ? {32'($urandom), 1'b0, 8'hFF, 23'($urandom_range(0, 1))}
                             : {1'($urandom), 11'h7FF, 52'($urandom_range(0, 1))};
      6: return ty == TY_F32 ? {32'($urandom), 1'($urandom), 31'd0}
                             : {1'($urandom), 63'd0};
      7: return ty == TY_F32 ? {32'($urandom), 1'($urandom), 8'd0, 23'($urandom)}
                             : {1'($urandom), 11'd0, 52'({$urandom, $urandom})};
      8: return {1'($urandom), 11'($urandom_range(1000, 1080)), 52'({$urandom, $urandom})};
      default: return {32'd0, 1'($urandom), 8'($urandom_range(120, 190)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [3:0] pick_type();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 4'($urandom_range(11, 15));
    return 4'($urandom_range(0, 10));
  endfunction

  task automatic send(input logic [63:0] pv, input logic [3:0] pt, input logic [63:0] lov,
                      input logic [3:0] lot, input logic [63:0] hiv, input logic [3:0] hit,
                      input logic [2:0] op, input logic col_left, input logic stats,
                      input logic last, input int gap);
    for (int i = 0; i < gap; i++) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pred_value <= pv;
    pred_type <= pt;
    min_stat <= lov;
    min_type <= lot;
    max_stat <= hiv;
    max_type <= hit;
    op_code <= op;
    col_on_left <= col_left;
    stats_present <= stats;
    last_predicate <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int gap);
    logic [3:0]  pt;
    logic [3:0]  lot;
    logic [3:0]  hit;
    logic [63:0] pv;
    logic [63:0] lov;
    logic [63:0] hiv;
    pt = pick_type();
    lot = ($urandom_range(0, 2) != 0) ? pt : pick_type();
    hit = ($urandom_range(0, 3) != 0) ? lot : pick_type();
    pv = pick_raw(pt);
    lov = pick_raw(lot);
    hiv = pick_raw(hit);
    // land on the zone boundaries now and then
    case ($urandom_range(0, 5))
      0: lov = pv;
      1: hiv = pv;
      2: begin lov = pv - 64'd1; hiv = pv + 64'd1; end
      default: ;
    endcase
    send(pv, pt, lov, lot, hiv, hit, 3'($urandom_range(0, 7)), 1'($urandom),
         $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0, gap);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: operators on both sides over a u8 zone [10, 20]
    for (int op = 0; op < 6; op++) begin
      send(64'd5, TY_U8, 64'd10, TY_U8, 64'd20, TY_U8, 3'(op), 1'b1, 1'b1, 1'b0, 0);
      send(64'd20, TY_U8, 64'd10, TY_U8, 64'd20, TY_U8, 3'(op), 1'b0, 1'b1, 1'b0, 0);
    end
    send(64'hFFFF_FFFF_FFFF_FF05, TY_U8, 64'd10, TY_U8, 64'd20, TY_U8, OP_EQ, 1'b1, 1'b1,
         1'b1, 1);
    // signed extremes, timestamp, u64 top value against i64
    send(64'h80, TY_I8, 64'h7F, TY_I8, 64'h7F, TY_I8, OP_LT, 1'b1, 1'b1, 1'b0, 0);
    send(64'h8000_0000_0000_0000, TY_TS, 64'd0, TY_TS, 64'd1, TY_TS, OP_GE, 1'b1, 1'b1,
         1'b0, 0);
    send('1, TY_U64, 64'h7FFF_FFFF_FFFF_FFFF, TY_I64, '1, TY_I64, OP_GT, 1'b0, 1'b1,
         1'b1, 0);
    // float: nan, signed zeros, infinity, mixed with integer
    send(64'h7FF8_0000_0000_0000, TY_F64, 64'd0, TY_F64, 64'd1, TY_F64, OP_EQ, 1'b1, 1'b1,
         1'b0, 2);
    send(64'h8000_0000, TY_F32, 64'd0, TY_F64, 64'd0, TY_F64, OP_LT, 1'b1, 1'b1, 1'b0, 0);
    send(64'h7F80_0000, TY_F32, 64'd5, TY_I32, 64'd9, TY_U16, OP_GT, 1'b1, 1'b1, 1'b1, 0);
    // missing stats, unsupported types on each operand
    send(64'd0, TY_U8, 64'd10, TY_U8, 64'd20, TY_U8, OP_LT, 1'b1, 1'b0, 1'b0, 0);
    send(64'd0, TY_BAD, 64'd10, TY_U8, 64'd20, TY_U8, OP_LT, 1'b1, 1'b1, 1'b0, 0);
    send(64'd0, TY_U8, 64'd10, 4'd15, 64'd20, 4'd15, OP_LT, 1'b1, 1'b1, 1'b0, 0);
    send(64'd0, 4'd12, 64'd10, 4'd12, 64'd20, 4'd12, OP_EQ, 1'b1, 1'b1, 1'b1, 0);
    send(64'd0, TY_U8, 64'd10, TY_U8, 64'd20, TY_U8, 3'd7, 1'b0, 1'b1, 1'b1, 0);
    drain();

    for (int n = 0; n < RandomBeats; n++) begin
      if (n == 600) stall_enable = 1'b0;
      if (n == 800) stall_enable = 1'b1;
      if (n == 1200) drain();
      send_random((n >= 600 && n < 800) ? 0 : $urandom_range(0, 6));
    end
    drain();
    repeat (20) @(posedge clk);

    $display("checked %0d result beats, %0d predicates pruned on their own",
             checked_count, pruned_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mmspc_pkg.sv
sv/mmspc_front.sv
sv/mmspc_queue.sv
sv/mmspc_back.sv
sv/min_max_segment_prune_check.sv
test/prune_check_monitor.sv
test/testbench.sv
